FILE: design/jbpi_pkg.sv
// Shared types, constants and index tables for the inverse bind matrix block.
`default_nettype none

package jbpi_pkg;

    localparam int MAX_JOINTS_DEF = 64;
    localparam int FRAC_BITS_DEF  = 16;

    // Configuration register index (byte address bit 2)
    localparam logic REG_DET_THRESHOLD = 1'b0;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SINGULAR = 2'd1,
        ST_PARENT   = 2'd2
    } status_t;

    // Clamp a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return 32'sh7fff_ffff;
        else if (x < -64'sd2147483648)
            return 32'sh8000_0000;
        else
            return x[31:0];
    endfunction

    // Quaternion component for operand A of quaternion product step (x,y,z,w = 0..3)
    function automatic logic [1:0] quat_a(input logic [3:0] step);
        case (step)
            4'd0, 4'd3, 4'd4: return 2'd0;
            4'd1, 4'd5:       return 2'd1;
            4'd2:             return 2'd2;
            default:          return 2'd3;
        endcase
    endfunction

    // Quaternion component for operand B of quaternion product step
    function automatic logic [1:0] quat_b(input logic [3:0] step);
        case (step)
            4'd0, 4'd6: return 2'd0;
            4'd1, 4'd3, 4'd7: return 2'd1;
            default:    return 2'd2;
        endcase
    endfunction

    // Local matrix element written by scaled rotation step k
    function automatic logic [3:0] loc_elem(input logic [3:0] k);
        case (k)
            4'd0: return 4'd0;
            4'd1: return 4'd1;
            4'd2: return 4'd2;
            4'd3: return 4'd4;
            4'd4: return 4'd5;
            4'd5: return 4'd6;
            4'd6: return 4'd8;
            4'd7: return 4'd9;
            default: return 4'd10;
        endcase
    endfunction

    // Matrix element for minor row n of term t of cofactor e (e = r + 4c)
    function automatic logic [3:0] cof_addr(input logic [3:0] e, input logic [2:0] t,
                                            input logic [1:0] n);
        logic [1:0] r;
        logic [1:0] c;
        logic [1:0] row;
        logic [1:0] pc;
        logic [1:0] col;
        logic [5:0] pv;
        r = e[1:0];
        c = e[3:2];
        row = (n < c) ? n : n + 2'd1;
        case (t)
            3'd0:    pv = {2'd2, 2'd1, 2'd0};
            3'd1:    pv = {2'd1, 2'd2, 2'd0};
            3'd2:    pv = {2'd2, 2'd0, 2'd1};
            3'd3:    pv = {2'd0, 2'd2, 2'd1};
            3'd4:    pv = {2'd1, 2'd0, 2'd2};
            3'd5:    pv = {2'd0, 2'd1, 2'd2};
            default: pv = {2'd2, 2'd1, 2'd0};
        endcase
        pc = pv[{n, 1'b0} +: 2];
        col = (pc < r) ? pc : pc + 2'd1;
        return {col, row};
    endfunction

    // Odd permutations enter the 3x3 determinant with a minus sign
    function automatic logic cof_neg(input logic [2:0] t);
        return (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
    endfunction

endpackage

`default_nettype wire

FILE: design/joint_bind_pose_inverse_top.sv
// Top level: sequencer around one shared multiplier, the divider and the world store.
// Per joint, in order: local build, parent product (a copy for a root), store write,
// cofactors, determinant, then one division per element.
// One joint at a time; in_ready is high only while idle. Reset clears the joint
// counter, det_threshold (to 1) and all control; the world store is not cleared.
`default_nettype none

module joint_bind_pose_inverse_top #(
    parameter int MAX_JOINTS = jbpi_pkg::MAX_JOINTS_DEF,
    parameter int FRAC_BITS  = jbpi_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output      logic [31:0]        prdata,
    output      logic               pready,
    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire logic signed [31:0] trans_x,
    input  wire logic signed [31:0] trans_y,
    input  wire logic signed [31:0] trans_z,
    input  wire logic signed [17:0] quat_x,
    input  wire logic signed [17:0] quat_y,
    input  wire logic signed [17:0] quat_z,
    input  wire logic signed [17:0] quat_w,
    input  wire logic signed [31:0] scale_x,
    input  wire logic signed [31:0] scale_y,
    input  wire logic signed [31:0] scale_z,
    input  wire logic signed [6:0]  parent_index,
    input  wire logic               first_joint,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic signed [31:0] element_value,
    output      logic [3:0]         element_index,
    output      logic [5:0]         joint_number,
    output      logic [1:0]         status,
    output      logic               last
);

    localparam int JW    = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int AW    = JW + 4;
    localparam int DEPTH = MAX_JOINTS * 16;
    localparam int RW    = 64 - FRAC_BITS;
    localparam int DW    = RW + 2;
    localparam int NW    = 32 + FRAC_BITS;
    localparam int CMPW  = JW + 7;
    localparam logic signed [31:0] ONE   = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [33:0] ONE34 = 34'sd1 <<< FRAC_BITS;

    typedef enum logic [4:0] {
        S_IDLE,
        S_LOC_A,
        S_LOC_M,
        S_LOC_U,
        S_COPY,
        S_WLD_A,
        S_WLD_M,
        S_WLD_U,
        S_STORE,
        S_COF_A,
        S_COF_M1,
        S_COF_U1,
        S_COF_M2,
        S_COF_U2,
        S_DET_A,
        S_DET_M,
        S_DET_U,
        S_CHECK,
        S_DIV_START,
        S_DIV_WAIT,
        S_ONE
    } state_t;

    state_t             state_reg;
    logic [4:0]         step_reg;
    logic [3:0]         e_reg;
    logic [1:0]         k_reg;
    logic [2:0]         t_reg;
    logic [JW-1:0]      cnt_reg;
    logic [JW-1:0]      j_reg;
    logic [JW-1:0]      par_reg;
    logic               direct_reg;
    logic               bad_reg;
    jbpi_pkg::status_t  pend_st_reg;
    logic [30:0]        thr_reg;

    logic               out_valid_reg;
    logic signed [31:0] val_reg;
    logic [3:0]         idx_reg;
    logic [5:0]         jn_reg;
    jbpi_pkg::status_t  st_reg;
    logic               last_reg;

    logic signed [17:0] q_reg [4];
    logic signed [31:0] s_reg [3];
    logic signed [31:0] qp_reg [9];
    logic signed [31:0] loc_reg [16];
    logic signed [31:0] wld_reg [16];
    logic signed [31:0] inv_reg [16];
    logic signed [31:0] opa_reg;
    logic signed [DW-1:0] acc_reg;
    logic signed [35:0] cof_reg;

    logic               mul_en;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [RW-1:0] rnd;
    logic signed [31:0] rnd_sat;
    logic [3:0]         ks;
    logic signed [33:0] mid;
    logic [3:0]         wld_ra;
    logic [3:0]         inv_ra;
    logic signed [31:0] wld_rd;
    logic signed [31:0] inv_rd;
    logic signed [31:0] loc_rd;
    logic [AW-1:0]      st_raddr;
    logic signed [31:0] st_rdata;
    logic               st_we;

    logic [JW-1:0]      j_new;
    logic               p_root;
    logic               p_bad;
    logic signed [DW-1:0] wsum;
    logic signed [DW-1:0] dsum;
    logic signed [35:0] term;
    logic signed [35:0] csum;
    logic signed [31:0] cdet;
    logic signed [31:0] cadj;
    logic [DW-1:0]      det_mag;
    logic               singular;
    logic [31:0]        inv_mag;
    logic               div_start;
    logic               div_done;
    logic signed [31:0] div_result;
    logic               out_free;
    logic               out_load;
    logic               cfg_we;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == jbpi_pkg::REG_DET_THRESHOLD);
    assign prdata = (paddr[2] == jbpi_pkg::REG_DET_THRESHOLD) ? {1'b0, thr_reg} : '0;

    // Joint number and parent check for the incoming transaction
    assign j_new  = first_joint ? '0 : cnt_reg;
    assign p_root = (parent_index == -7'sd1);
    assign p_bad  = parent_index[6] ? !p_root :
                    (CMPW'(unsigned'(parent_index[5:0])) >= CMPW'(j_new));

    // Operand selection for the shared multiplier
    assign ks      = 4'(step_reg - 5'd9);
    assign rnd_sat = jbpi_pkg::sat32(64'(rnd));
    assign loc_rd  = loc_reg[{e_reg[3:2], k_reg}];
    assign wld_rd  = wld_reg[wld_ra];
    assign inv_rd  = inv_reg[inv_ra];
    assign mul_a   = (state_reg == S_WLD_M) ? st_rdata : opa_reg;
    assign mul_en  = (state_reg == S_LOC_M) || (state_reg == S_WLD_M) ||
                     (state_reg == S_COF_M1) || (state_reg == S_COF_M2) ||
                     (state_reg == S_DET_M);

    always_comb
    begin
        case (ks)
            4'd0: mid = ONE34 - ((34'(qp_reg[1]) + 34'(qp_reg[2])) <<< 1);
            4'd1: mid = (34'(qp_reg[3]) + 34'(qp_reg[8])) <<< 1;
            4'd2: mid = (34'(qp_reg[4]) - 34'(qp_reg[7])) <<< 1;
            4'd3: mid = (34'(qp_reg[3]) - 34'(qp_reg[8])) <<< 1;
            4'd4: mid = ONE34 - ((34'(qp_reg[0]) + 34'(qp_reg[2])) <<< 1);
            4'd5: mid = (34'(qp_reg[5]) + 34'(qp_reg[6])) <<< 1;
            4'd6: mid = (34'(qp_reg[4]) + 34'(qp_reg[7])) <<< 1;
            4'd7: mid = (34'(qp_reg[5]) - 34'(qp_reg[6])) <<< 1;
            default: mid = ONE34 - ((34'(qp_reg[0]) + 34'(qp_reg[1])) <<< 1);
        endcase
    end

    always_comb
    begin
        wld_ra = e_reg;
        inv_ra = e_reg;
        mul_b  = '0;
        case (state_reg)
            S_LOC_M:
            begin
                if (step_reg < 5'd9)
                    mul_b = 32'(q_reg[jbpi_pkg::quat_b(step_reg[3:0])]);
                else
                    mul_b = 32'(mid);
            end
            S_WLD_M:  mul_b = loc_rd;
            S_COF_A:  wld_ra = jbpi_pkg::cof_addr(e_reg, t_reg, 2'd0);
            S_COF_M1:
            begin
                wld_ra = jbpi_pkg::cof_addr(e_reg, t_reg, 2'd1);
                mul_b  = wld_rd;
            end
            S_COF_M2:
            begin
                wld_ra = jbpi_pkg::cof_addr(e_reg, t_reg, 2'd2);
                mul_b  = wld_rd;
            end
            S_DET_A:  wld_ra = {2'b00, k_reg};
            S_DET_M:
            begin
                inv_ra = {k_reg, 2'b00};
                mul_b  = inv_rd;
            end
            default:  mul_b = '0;
        endcase
    end

    // Accumulations and cofactor sign
    assign wsum = acc_reg + DW'(rnd);
    assign dsum = acc_reg + DW'(rnd);
    assign term = 36'(rnd_sat);
    assign csum = jbpi_pkg::cof_neg(t_reg) ? cof_reg - term : cof_reg + term;
    assign cdet = jbpi_pkg::sat32(64'(csum));
    assign cadj = (e_reg[0] ^ e_reg[2]) ?
                  ((cdet == 32'sh8000_0000) ? 32'sh7fff_ffff : -cdet) : cdet;

    // Determinant test and divider operands
    assign det_mag   = acc_reg[DW-1] ? DW'(-acc_reg) : DW'(acc_reg);
    assign singular  = (acc_reg == '0) || (det_mag < DW'(thr_reg));
    assign inv_mag   = inv_rd[31] ? 32'(-inv_rd) : 32'(inv_rd);
    assign div_start = (state_reg == S_DIV_START);
    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = out_free && (((state_reg == S_DIV_WAIT) && div_done) ||
                                    (state_reg == S_ONE));

    // World store ports
    assign st_we    = (state_reg == S_STORE);
    assign st_raddr = {par_reg, k_reg, e_reg[1:0]};

    jbpi_mul #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .rnd (rnd)
    );

    jbpi_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .num_mag (NW'(inv_mag) << FRAC_BITS),
        .den_mag (det_mag),
        .neg     (inv_rd[31] ^ acc_reg[DW-1]),
        .done    (div_done),
        .result  (div_result)
    );

    jbpi_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr ({j_reg, e_reg}),
        .wdata (wld_rd),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            e_reg         <= '0;
            k_reg         <= '0;
            t_reg         <= '0;
            cnt_reg       <= '0;
            j_reg         <= '0;
            par_reg       <= '0;
            direct_reg    <= 1'b0;
            bad_reg       <= 1'b0;
            pend_st_reg   <= jbpi_pkg::ST_OK;
            thr_reg       <= 31'd1;
            out_valid_reg <= 1'b0;
            val_reg       <= '0;
            idx_reg       <= '0;
            jn_reg        <= '0;
            st_reg        <= jbpi_pkg::ST_OK;
            last_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                thr_reg <= pwdata[30:0];
            if (out_valid_reg && out_ready && !out_load)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        j_reg      <= j_new;
                        cnt_reg    <= (j_new == JW'(MAX_JOINTS - 1)) ? '0 : j_new + 1'b1;
                        par_reg    <= JW'(unsigned'(parent_index[5:0]));
                        direct_reg <= p_root || p_bad;
                        bad_reg    <= p_bad;
                        step_reg   <= '0;
                        state_reg  <= S_LOC_A;
                    end
                end
                S_LOC_A: state_reg <= S_LOC_M;
                S_LOC_M: state_reg <= S_LOC_U;
                S_LOC_U:
                begin
                    e_reg <= '0;
                    k_reg <= '0;
                    if (step_reg == 5'd17)
                        state_reg <= direct_reg ? S_COPY : S_WLD_A;
                    else
                    begin
                        step_reg  <= step_reg + 1'b1;
                        state_reg <= S_LOC_A;
                    end
                end
                S_COPY: state_reg <= S_STORE;
                S_WLD_A: state_reg <= S_WLD_M;
                S_WLD_M: state_reg <= S_WLD_U;
                S_WLD_U:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == 2'd3)
                    begin
                        e_reg     <= e_reg + 1'b1;
                        state_reg <= (e_reg == 4'd15) ? S_STORE : S_WLD_A;
                    end
                    else
                        state_reg <= S_WLD_A;
                end
                S_STORE:
                begin
                    e_reg <= e_reg + 1'b1;
                    t_reg <= '0;
                    if (e_reg == 4'd15)
                    begin
                        if (bad_reg)
                        begin
                            pend_st_reg <= jbpi_pkg::ST_PARENT;
                            state_reg   <= S_ONE;
                        end
                        else
                            state_reg <= S_COF_A;
                    end
                end
                S_COF_A:  state_reg <= S_COF_M1;
                S_COF_M1: state_reg <= S_COF_U1;
                S_COF_U1: state_reg <= S_COF_M2;
                S_COF_M2: state_reg <= S_COF_U2;
                S_COF_U2:
                begin
                    k_reg <= '0;
                    if (t_reg == 3'd5)
                    begin
                        t_reg     <= '0;
                        e_reg     <= e_reg + 1'b1;
                        state_reg <= (e_reg == 4'd15) ? S_DET_A : S_COF_A;
                    end
                    else
                    begin
                        t_reg     <= t_reg + 1'b1;
                        state_reg <= S_COF_A;
                    end
                end
                S_DET_A: state_reg <= S_DET_M;
                S_DET_M: state_reg <= S_DET_U;
                S_DET_U:
                begin
                    k_reg     <= k_reg + 1'b1;
                    state_reg <= (k_reg == 2'd3) ? S_CHECK : S_DET_A;
                end
                S_CHECK:
                begin
                    e_reg <= '0;
                    if (singular)
                    begin
                        pend_st_reg <= jbpi_pkg::ST_SINGULAR;
                        state_reg   <= S_ONE;
                    end
                    else
                        state_reg <= S_DIV_START;
                end
                S_DIV_START: state_reg <= S_DIV_WAIT;
                S_DIV_WAIT:
                begin
                    if (div_done && out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        val_reg       <= div_result;
                        idx_reg       <= e_reg;
                        jn_reg        <= 6'(j_reg);
                        st_reg        <= jbpi_pkg::ST_OK;
                        last_reg      <= (e_reg == 4'd15);
                        e_reg         <= e_reg + 1'b1;
                        state_reg     <= (e_reg == 4'd15) ? S_IDLE : S_DIV_START;
                    end
                end
                S_ONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        val_reg       <= '0;
                        idx_reg       <= '0;
                        jn_reg        <= 6'(j_reg);
                        st_reg        <= pend_st_reg;
                        last_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers: operands, matrices and accumulators
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    q_reg[0]    <= quat_x;
                    q_reg[1]    <= quat_y;
                    q_reg[2]    <= quat_z;
                    q_reg[3]    <= quat_w;
                    s_reg[0]    <= scale_x;
                    s_reg[1]    <= scale_y;
                    s_reg[2]    <= scale_z;
                    loc_reg[3]  <= '0;
                    loc_reg[7]  <= '0;
                    loc_reg[11] <= '0;
                    loc_reg[12] <= trans_x;
                    loc_reg[13] <= trans_y;
                    loc_reg[14] <= trans_z;
                    loc_reg[15] <= ONE;
                end
            end
            S_LOC_A:
            begin
                if (step_reg < 5'd9)
                    opa_reg <= 32'(q_reg[jbpi_pkg::quat_a(step_reg[3:0])]);
                else
                    opa_reg <= s_reg[(ks < 4'd3) ? 2'd0 : ((ks < 4'd6) ? 2'd1 : 2'd2)];
            end
            S_LOC_U:
            begin
                if (step_reg < 5'd9)
                    qp_reg[step_reg[3:0]] <= 32'(rnd);
                else
                    loc_reg[jbpi_pkg::loc_elem(ks)] <= rnd_sat;
                acc_reg <= '0;
            end
            S_COPY:
            begin
                for (int i = 0; i < 16; i++)
                    wld_reg[i] <= loc_reg[i];
            end
            S_WLD_U:
            begin
                if (k_reg == 2'd3)
                begin
                    wld_reg[e_reg] <= jbpi_pkg::sat32(64'(wsum));
                    acc_reg        <= '0;
                end
                else
                    acc_reg <= wsum;
                cof_reg <= '0;
            end
            S_STORE:
            begin
                cof_reg <= '0;
            end
            S_COF_A:  opa_reg <= wld_rd;
            S_COF_U1: opa_reg <= rnd_sat;
            S_COF_U2:
            begin
                if (t_reg == 3'd5)
                begin
                    inv_reg[e_reg] <= cadj;
                    cof_reg        <= '0;
                end
                else
                    cof_reg <= csum;
                acc_reg <= '0;
            end
            S_DET_A:  opa_reg <= wld_rd;
            S_DET_U:  acc_reg <= dsum;
            default:  opa_reg <= opa_reg;
        endcase
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign element_value = val_reg;
    assign element_index = idx_reg;
    assign joint_number  = jn_reg;
    assign status        = st_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire

FILE: design/jbpi_mul.sv
// Shared signed 32x32 multiplier with fixed point rounding.
`default_nettype none

module jbpi_mul #(
    parameter int FRAC_BITS = jbpi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       en,
    input  wire logic signed [31:0]         a,
    input  wire logic signed [31:0]         b,
    output      logic signed [63-FRAC_BITS:0] rnd
);

    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    logic signed [63:0] prod_reg;

    // Multiply and add half an LSB of the result
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= (64'(a) * 64'(b)) + HALF;
        end
    end

    // Floor shift gives round to nearest, ties up
    assign rnd = prod_reg[63:FRAC_BITS];

endmodule

`default_nettype wire

FILE: design/jbpi_div.sv
// Restoring divider with round-half-away and 32-bit saturation.
`default_nettype none

module jbpi_div #(
    parameter int NW = 48,
    parameter int DW = 50
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [NW-1:0]       num_mag,
    input  wire logic [DW-1:0]       den_mag,
    input  wire logic                neg,
    output      logic                done,
    output      logic signed [31:0]  result
);

    localparam int CW = $clog2(NW);

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_RND,
        D_SAT
    } dstate_t;

    dstate_t          state_reg;
    logic [CW-1:0]    cnt_reg;
    logic [NW-1:0]    num_reg;
    logic [NW-1:0]    quo_reg;
    logic [DW-1:0]    rem_reg;
    logic [DW-1:0]    den_reg;
    logic             neg_reg;
    logic [NW:0]      qm_reg;
    logic             done_reg;
    logic signed [31:0] result_reg;

    logic [DW:0]      trial;
    logic             ge;
    logic             up;

    // One quotient bit per cycle
    assign trial = {rem_reg, num_reg[NW-1]};
    assign ge    = trial >= {1'b0, den_reg};
    assign up    = {rem_reg, 1'b0} >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= D_IDLE;
            cnt_reg    <= '0;
            num_reg    <= '0;
            quo_reg    <= '0;
            rem_reg    <= '0;
            den_reg    <= '0;
            neg_reg    <= 1'b0;
            qm_reg     <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        num_reg   <= num_mag;
                        den_reg   <= den_mag;
                        neg_reg   <= neg;
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                        cnt_reg   <= CW'(NW - 1);
                        done_reg  <= 1'b0;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    rem_reg <= ge ? DW'(trial - {1'b0, den_reg}) : DW'(trial);
                    quo_reg <= {quo_reg[NW-2:0], ge};
                    num_reg <= num_reg << 1;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                    begin
                        state_reg <= D_RND;
                    end
                end
                D_RND:
                begin
                    // Round half away from zero on the magnitude
                    qm_reg    <= {1'b0, quo_reg} + (NW+1)'(up);
                    state_reg <= D_SAT;
                end
                D_SAT:
                begin
                    if (neg_reg)
                        result_reg <= (qm_reg > (NW+1)'(32'h8000_0000)) ?
                                      32'sh8000_0000 : -$signed(qm_reg[31:0]);
                    else
                        result_reg <= (qm_reg > (NW+1)'(32'h7fff_ffff)) ?
                                      32'sh7fff_ffff : $signed(qm_reg[31:0]);
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

FILE: design/jbpi_store.sv
// Per-joint world matrix memory, one write and one registered read port.
`default_nettype none

module jbpi_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic                clk,
    input  wire logic                we,
    input  wire logic [AW-1:0]       waddr,
    input  wire logic signed [31:0]  wdata,
    input  wire logic [AW-1:0]       raddr,
    output      logic signed [31:0]  rdata
);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: design/jbpi_checker.sv
// Port-level checker for the inverse bind matrix block, bound to the top level.
`default_nettype none

module jbpi_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [31:0] element_value,
    input wire logic [3:0]         element_index,
    input wire logic [5:0]         joint_number,
    input wire logic [1:0]         status,
    input wire logic               last
);

    // Hold a stalled result transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(element_value) &&
        $stable(element_index) && $stable(joint_number) && $stable(status) &&
        $stable(last))
        else $error("stalled result changed");

    // Status results carry a zero element and close the joint
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != jbpi_pkg::ST_OK) |->
        last && (element_index == 4'd0) && (element_value == 32'sd0))
        else $error("malformed status result");

    // Matrix results close on the final element only
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == jbpi_pkg::ST_OK) |-> (last == (element_index == 4'd15)))
        else $error("last flag misplaced");

    // Drop ready once a joint is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second joint accepted while busy");

endmodule

bind joint_bind_pose_inverse_top jbpi_checker u_jbpi_checker (.*);

`default_nettype wire

FILE: dv/joint_bind_pose_inverse_checker.sv
// Checker for the inverse bind matrix block: predicts each joint's results and compares them.
`timescale 1ns / 100ps
`default_nettype none

module joint_bind_pose_inverse_checker #(
    parameter int MAX_JOINTS = jbpi_pkg::MAX_JOINTS_DEF,
    parameter int FRAC_BITS  = jbpi_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    input  wire logic               pready,
    input  wire logic               in_valid,
    input  wire logic               in_ready,
    input  wire logic signed [31:0] trans_x,
    input  wire logic signed [31:0] trans_y,
    input  wire logic signed [31:0] trans_z,
    input  wire logic signed [17:0] quat_x,
    input  wire logic signed [17:0] quat_y,
    input  wire logic signed [17:0] quat_z,
    input  wire logic signed [17:0] quat_w,
    input  wire logic signed [31:0] scale_x,
    input  wire logic signed [31:0] scale_y,
    input  wire logic signed [31:0] scale_z,
    input  wire logic signed [6:0]  parent_index,
    input  wire logic               first_joint,
    input  wire logic               out_valid,
    input  wire logic               out_ready,
    input  wire logic signed [31:0] element_value,
    input  wire logic [3:0]         element_index,
    input  wire logic [5:0]         joint_number,
    input  wire logic [1:0]         status,
    input  wire logic               last,
    output int                      errors,
    output int                      pending,
    output int                      elements_checked,
    output int                      singular_seen,
    output int                      parent_err_seen
);

    typedef struct {
        logic signed [31:0] value;
        logic [3:0]         index;
        logic [5:0]         joint;
        jbpi_pkg::status_t  st;
        logic               fin;
    } element_t;

    localparam longint ONE  = longint'(1) << FRAC_BITS;
    localparam longint HALF = longint'(1) << (FRAC_BITS - 1);

    element_t       expected_elements[$];
    longint         world_mat[MAX_JOINTS * 16];
    int unsigned    joint_ctr;
    longint         det_limit;

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    // Exact product, rounded to nearest with halves toward plus infinity
    function automatic longint fx_mul(longint a, longint b);
        longint y;
        y = a * b + HALF;
        return y >>> FRAC_BITS;
    endfunction

    function automatic longint fx_mul_sat(longint a, longint b);
        return clamp32(fx_mul(a, b));
    endfunction

    function automatic longint triple(longint x, longint y, longint z);
        return fx_mul_sat(fx_mul_sat(x, y), z);
    endfunction

    // Signed cofactor of inverse element (r,c): drop row c and column r
    function automatic longint cofactor_of(longint m[16], int r, int c);
        longint a[3][3];
        longint d;
        int ri;
        int ci;
        ri = 0;
        for (int i = 0; i < 4; i++) begin
            if (i == c)
                continue;
            ci = 0;
            for (int k = 0; k < 4; k++) begin
                if (k == r)
                    continue;
                a[ri][ci] = m[i + 4 * k];
                ci++;
            end
            ri++;
        end
        d = triple(a[0][0], a[1][1], a[2][2]) - triple(a[0][0], a[1][2], a[2][1])
          - triple(a[0][1], a[1][0], a[2][2]) + triple(a[0][1], a[1][2], a[2][0])
          + triple(a[0][2], a[1][0], a[2][1]) - triple(a[0][2], a[1][1], a[2][0]);
        d = clamp32(d);
        if (((r + c) & 1) != 0)
            d = -d;
        return clamp32(d);
    endfunction

    // Quotient rounded to nearest, ties away from zero
    function automatic longint div_nearest(longint num, longint den);
        longint q;
        longint rem;
        longint ar;
        longint ad;
        q = num / den;
        rem = num % den;
        ar = (rem < 0) ? -rem : rem;
        ad = (den < 0) ? -den : den;
        if (2 * ar >= ad)
            q = ((num < 0) != (den < 0)) ? q - 1 : q + 1;
        return clamp32(q);
    endfunction

    // Build, chain, store and invert one joint; queue its elements
    task automatic predict_joint();
        longint t[3];
        longint s[3];
        longint q[4];
        longint loc[16];
        longint wld[16];
        longint inv[16];
        longint p;
        longint det;
        longint ad;
        longint sum;
        longint xx, yy, zz, xy, xz, yz, wx, wy, wz;
        int unsigned j;
        jbpi_pkg::status_t st;
        element_t e;
        t[0] = trans_x; t[1] = trans_y; t[2] = trans_z;
        s[0] = scale_x; s[1] = scale_y; s[2] = scale_z;
        q[0] = quat_x; q[1] = quat_y; q[2] = quat_z; q[3] = quat_w;
        p = parent_index;
        st = jbpi_pkg::ST_OK;
        if (first_joint)
            joint_ctr = 0;
        j = (joint_ctr >= MAX_JOINTS) ? 0 : joint_ctr;

        xx = fx_mul(q[0], q[0]); yy = fx_mul(q[1], q[1]); zz = fx_mul(q[2], q[2]);
        xy = fx_mul(q[0], q[1]); xz = fx_mul(q[0], q[2]); yz = fx_mul(q[1], q[2]);
        wx = fx_mul(q[3], q[0]); wy = fx_mul(q[3], q[1]); wz = fx_mul(q[3], q[2]);
        loc[0]  = fx_mul_sat(s[0], ONE - 2 * (yy + zz));
        loc[1]  = fx_mul_sat(s[0], 2 * (xy + wz));
        loc[2]  = fx_mul_sat(s[0], 2 * (xz - wy));
        loc[4]  = fx_mul_sat(s[1], 2 * (xy - wz));
        loc[5]  = fx_mul_sat(s[1], ONE - 2 * (xx + zz));
        loc[6]  = fx_mul_sat(s[1], 2 * (yz + wx));
        loc[8]  = fx_mul_sat(s[2], 2 * (xz + wy));
        loc[9]  = fx_mul_sat(s[2], 2 * (yz - wx));
        loc[10] = fx_mul_sat(s[2], ONE - 2 * (xx + yy));
        loc[3] = 0; loc[7] = 0; loc[11] = 0;
        loc[12] = t[0]; loc[13] = t[1]; loc[14] = t[2];
        loc[15] = ONE;

        // Root keeps the local matrix; a bad parent keeps it and flags the joint
        if (p == -1)
            wld = loc;
        else if (p < 0 || p >= longint'(j)) begin
            wld = loc;
            st = jbpi_pkg::ST_PARENT;
        end
        else begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++) begin
                    sum = 0;
                    for (int k = 0; k < 4; k++)
                        sum += fx_mul(world_mat[p * 16 + r + 4 * k], loc[k + 4 * c]);
                    wld[r + 4 * c] = clamp32(sum);
                end
        end
        for (int i = 0; i < 16; i++)
            world_mat[j * 16 + i] = wld[i];
        joint_ctr = (j + 1 >= MAX_JOINTS) ? 0 : j + 1;

        if (st == jbpi_pkg::ST_OK) begin
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    inv[r + 4 * c] = cofactor_of(wld, r, c);
            det = 0;
            for (int r = 0; r < 4; r++)
                det += fx_mul(wld[r], inv[4 * r]);
            ad = (det < 0) ? -det : det;
            if (det == 0 || ad < det_limit)
                st = jbpi_pkg::ST_SINGULAR;
            else begin
                for (int i = 0; i < 16; i++) begin
                    e.value = 32'(div_nearest(inv[i] * ONE, det));
                    e.index = 4'(i);
                    e.joint = j[5:0];
                    e.st = jbpi_pkg::ST_OK;
                    e.fin = (i == 15);
                    expected_elements = {expected_elements, e};
                end
                return;
            end
        end
        e.value = 0;
        e.index = 0;
        e.joint = j[5:0];
        e.st = st;
        e.fin = 1'b1;
        expected_elements = {expected_elements, e};
    endtask

    // Follow register writes, predict accepted joints, compare accepted elements
    always @(posedge clk or negedge rst_n)
    begin
        element_t e;
        if (!rst_n) begin
            joint_ctr = 0;
            det_limit = 1;
            expected_elements.delete();
            errors = 0;
            elements_checked = 0;
            singular_seen = 0;
            parent_err_seen = 0;
        end
        else begin
            if (psel && penable && pwrite && pready &&
                paddr[2] == jbpi_pkg::REG_DET_THRESHOLD)
                det_limit = pwdata[30:0];
            if (in_valid && in_ready)
                predict_joint();
            if (out_valid && out_ready) begin
                if (expected_elements.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected element value=%0d index=%0d joint=%0d status=%0d",
                             $time, element_value, element_index, joint_number, status);
                end
                else begin
                    e = expected_elements.pop_front();
                    elements_checked++;
                    if (status == jbpi_pkg::ST_SINGULAR)
                        singular_seen++;
                    if (status == jbpi_pkg::ST_PARENT)
                        parent_err_seen++;
                    if (element_value !== e.value || element_index !== e.index ||
                        joint_number !== e.joint || status !== e.st || last !== e.fin) begin
                        errors++;
                        $display("%0t: mismatch expected value=%0d index=%0d joint=%0d %s%0d%s%0d",
                                 $time, e.value, e.index, e.joint, "status=", e.st,
                                 " last=", e.fin);
                        $display("%0t:          actual   value=%0d index=%0d joint=%0d %s%0d%s%0d",
                                 $time, element_value, element_index, joint_number,
                                 "status=", status, " last=", last);
                    end
                end
            end
        end
        pending = expected_elements.size();
    end

endmodule

`default_nettype wire

FILE: dv/joint_bind_pose_inverse_top_tb.sv
// Testbench top: drives joints and register writes into the block and reports the verdict.
`timescale 1ns / 100ps
`default_nettype none

module joint_bind_pose_inverse_top_tb;

    localparam longint CYCLE_LIMIT = 4000000;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] trans_x, trans_y, trans_z;
    logic signed [17:0] quat_x, quat_y, quat_z, quat_w;
    logic signed [31:0] scale_x, scale_y, scale_z;
    logic signed [6:0]  parent_index;
    logic               first_joint;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] element_value;
    logic [3:0]         element_index;
    logic [5:0]         joint_number;
    logic [1:0]         status;
    logic               last;

    int     errors;
    int     pending;
    int     elements_checked;
    int     singular_seen;
    int     parent_err_seen;
    longint cycles;
    int     joints_sent;
    int     next_joint;
    logic   calm;
    logic   hold_req;

    joint_bind_pose_inverse_top DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .trans_x(trans_x), .trans_y(trans_y), .trans_z(trans_z),
        .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
        .scale_x(scale_x), .scale_y(scale_y), .scale_z(scale_z),
        .parent_index(parent_index), .first_joint(first_joint),
        .out_valid(out_valid), .out_ready(out_ready),
        .element_value(element_value), .element_index(element_index),
        .joint_number(joint_number), .status(status), .last(last)
    );

    joint_bind_pose_inverse_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .trans_x(trans_x), .trans_y(trans_y), .trans_z(trans_z),
        .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
        .scale_x(scale_x), .scale_y(scale_y), .scale_z(scale_z),
        .parent_index(parent_index), .first_joint(first_joint),
        .out_valid(out_valid), .out_ready(out_ready),
        .element_value(element_value), .element_index(element_index),
        .joint_number(joint_number), .status(status), .last(last),
        .errors(errors), .pending(pending), .elements_checked(elements_checked),
        .singular_seen(singular_seen), .parent_err_seen(parent_err_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stop a hung run
    initial
    begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("timeout after %0d cycles, %0d elements outstanding", cycles, pending);
                $display("joint_bind_pose_inverse_top_tb failed");
                $finish;
            end
        end
    end

    // Receiver: random stalls, one long hold-off on request, none while calm
    initial
    begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ready = 1'b0;
                repeat (3000) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (calm)
                out_ready = 1'b1;
            else
                out_ready = ($urandom_range(0, 99) >= 37);
        end
    end

    // Register write with setup and enable phases while the block is idle
    task automatic write_threshold(logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {jbpi_pkg::REG_DET_THRESHOLD, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Drain all elements, then let the sequencer settle
    task automatic drain_joints();
        @(negedge clk);
        wait (pending == 0);
        repeat (60) @(posedge clk);
    endtask

    // Offer one joint, hold it until the transaction completes, then drop valid
    task automatic send_joint(logic signed [31:0] tx, logic signed [31:0] ty,
                              logic signed [31:0] tz, logic signed [17:0] qx,
                              logic signed [17:0] qy, logic signed [17:0] qz,
                              logic signed [17:0] qw, logic signed [31:0] sx,
                              logic signed [31:0] sy, logic signed [31:0] sz,
                              logic signed [6:0] par, logic first);
        int gap;
        if (!calm && $urandom_range(0, 99) < 37) begin
            gap = $urandom_range(1, 40);
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        else
            @(negedge clk);
        trans_x = tx; trans_y = ty; trans_z = tz;
        quat_x = qx; quat_y = qy; quat_z = qz; quat_w = qw;
        scale_x = sx; scale_y = sy; scale_z = sz;
        parent_index = par;
        first_joint = first;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        in_valid = 1'b0;
        next_joint = first ? 1 : (next_joint + 1) % jbpi_pkg::MAX_JOINTS_DEF;
        joints_sent++;
    endtask

    function automatic logic signed [17:0] rand_quat();
        return 18'($signed($urandom_range(0, 92682)) - 46341);
    endfunction

    function automatic logic signed [31:0] rand_scale();
        logic signed [31:0] m;
        m = $urandom_range(32768, 131072);
        return $urandom_range(0, 1) ? m : -m;
    endfunction

    function automatic logic signed [31:0] rand_trans();
        return $signed($urandom_range(0, 2097152)) - 1048576;
    endfunction

    function automatic logic signed [6:0] pick_parent(int jn);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return (jn == jbpi_pkg::MAX_JOINTS_DEF - 1 || $urandom_range(0, 1)) ?
                   7'($signed($urandom_range(0, 62)) - 64) : 7'($urandom_range(jn, 63));
        if (jn == 0 || pick < 20)
            return -7'sd1;
        return 7'($urandom_range(0, jn - 1));
    endfunction

    // Skeleton of well-formed joints, with some noise joints mixed in
    task automatic send_skeleton(int len);
        logic first;
        logic signed [17:0] nq[4];
        for (int k = 0; k < len; k++) begin
            first = (k == 0);
            if ($urandom_range(0, 99) < 10) begin
                first = first | $urandom_range(0, 1);
                foreach (nq[i])
                    nq[i] = 18'($signed($urandom_range(0, 131072)) - 65536);
                send_joint($urandom, $urandom, $urandom, nq[0], nq[1], nq[2], nq[3],
                           $urandom, $urandom, $urandom,
                           7'($urandom), first);
            end
            else
                send_joint(rand_trans(), rand_trans(), rand_trans(), rand_quat(),
                           rand_quat(), rand_quat(), rand_quat(), rand_scale(),
                           rand_scale(), rand_scale(),
                           pick_parent(first ? 0 : next_joint), first);
        end
    endtask

    task automatic random_phase(int count);
        int start;
        start = joints_sent;
        while (joints_sent - start < count)
            send_skeleton($urandom_range(1, 12));
    endtask

    initial
    begin
        logic [31:0] limits[5];
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0;
        trans_x = '0; trans_y = '0; trans_z = '0;
        quat_x = '0; quat_y = '0; quat_z = '0; quat_w = '0;
        scale_x = '0; scale_y = '0; scale_z = '0;
        parent_index = -7'sd1;
        first_joint = 1'b0;
        calm = 1'b0;
        hold_req = 1'b0;
        joints_sent = 0;
        next_joint = 0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: identity root, chained children, extremes, degenerate and bad parents
        send_joint(0, 0, 0, 0, 0, 0, 18'sd65536, 32'sd65536, 32'sd65536, 32'sd65536, -7'sd1, 1);
        send_joint(32'sd131072, -32'sd65536, 32'sd32768, 0, 0, 18'sd46341, 18'sd46341,
                   32'sd65536, 32'sd131072, 32'sd65536, 7'sd0, 0);
        send_joint(rand_trans(), 0, 0, 18'sd65536, 0, 0, 0, 32'sd98304, 32'sd65536,
                   -32'sd65536, 7'sd1, 0);
        send_joint(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 18'sd65536, 18'sd65536,
                   -18'sd65536, -18'sd65536, 32'sd65536, 32'sd65536, 32'sd65536, -7'sd1, 0);
        send_joint(0, 0, 0, -18'sd65536, -18'sd65536, -18'sd65536, -18'sd65536,
                   32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 7'sd2, 0);
        send_joint(0, 0, 0, 0, 0, 0, 18'sd65536, 32'sh8000_0000, 32'sh8000_0000,
                   32'sh8000_0000, -7'sd1, 0);
        send_joint(0, 0, 0, 0, 0, 0, 18'sd65536, 0, 32'sd65536, 32'sd65536, -7'sd1, 0);
        send_joint(0, 0, 0, 0, 0, 0, 0, 32'sd65536, 32'sd65536, 32'sd65536, -7'sd1, 0);
        send_joint(0, 0, 0, 0, 0, 0, 18'sd65536, 32'sd1, 32'sd1, 32'sd1, -7'sd1, 0);
        send_joint(0, 0, 0, 0, 0, 0, 18'sd65536, 32'sd65536, 32'sd65536, 32'sd65536,
                   7'sd9, 0);
        send_joint(0, 0, 0, 0, 0, 0, 18'sd65536, 32'sd65536, 32'sd65536, 32'sd65536,
                   7'sd63, 0);
        send_joint(0, 0, 0, 0, 0, 0, 18'sd65536, 32'sd65536, 32'sd65536, 32'sd65536,
                   -7'sd64, 0);
        send_joint(0, 0, 0, 0, 0, 0, 18'sd65536, 32'sd65536, 32'sd65536, 32'sd65536,
                   -7'sd2, 0);
        send_joint(rand_trans(), rand_trans(), rand_trans(), rand_quat(), rand_quat(),
                   rand_quat(), rand_quat(), rand_scale(), rand_scale(), rand_scale(),
                   7'sd3, 0);
        send_joint(0, 0, 0, 0, 0, 0, 18'sd65536, 32'sd65536, 32'sd65536, 32'sd65536,
                   -7'sd1, 1);
        send_joint(0, 0, 0, 0, 0, 0, 18'sd65536, 32'sd65536, 32'sd65536, 32'sd65536,
                   7'sd0, 0);

        // Pause the sender until every element is back
        drain_joints();

        // One skeleton long enough to wrap the joint counter
        send_skeleton(70);
        drain_joints();

        limits[0] = 32'd0;
        limits[1] = 32'd65536;
        limits[2] = 32'h7fff_ffff;
        limits[3] = $urandom_range(0, 32'h0100_0000);
        limits[4] = 32'd1;
        for (int ph = 0; ph < 5; ph++) begin
            write_threshold(limits[ph]);
            if (ph == 1)
                hold_req = 1'b1;
            calm = (ph == 3);
            random_phase(ph == 2 ? 20 : 75);
            drain_joints();
            calm = 1'b0;
        end

        @(negedge clk);
        in_valid = 1'b0;
        wait (pending == 0);
        repeat (200) @(posedge clk);
        $display("Sent %0d joints over 6 threshold settings; checked %0d elements,", joints_sent,
                 elements_checked);
        $display("%0d singular and %0d bad-parent statuses among them", singular_seen,
                 parent_err_seen);
        if (errors == 0 && pending == 0)
            $display("joint_bind_pose_inverse_top_tb passed");
        else
            $display("joint_bind_pose_inverse_top_tb failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: joint_bind_pose_inverse_top.f
design/jbpi_pkg.sv
design/jbpi_mul.sv
design/jbpi_div.sv
design/jbpi_store.sv
design/joint_bind_pose_inverse_top.sv
design/jbpi_checker.sv
dv/joint_bind_pose_inverse_checker.sv
dv/joint_bind_pose_inverse_top_tb.sv
